>>> rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// types, constants and helpers for the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int IN_W    = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 36;
   localparam int REM_W   = 60;
   localparam int ROOT_W  = 29;
   localparam int CX_W    = 40;
   localparam int ANG_W   = 24;
   localparam int TABLE_LEN = 24;

   localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);
   localparam logic signed [ANG_W-1:0] PI_Q20      = ANG_W'(3294198);
   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = ANG_W'(1647099);
   localparam logic signed [ANG_W-1:0] ROUND_Q20   = ANG_W'(64);
   localparam logic signed [14:0]      HALF_PI_Q13 = 15'sd12868;

   typedef struct packed {
      logic signed [PROD_W-1:0] wx;
      logic signed [PROD_W-1:0] yz;
      logic signed [PROD_W-1:0] xx;
      logic signed [PROD_W-1:0] yy;
      logic signed [PROD_W-1:0] wz;
      logic signed [PROD_W-1:0] xy;
      logic signed [PROD_W-1:0] zz;
      logic signed [PROD_W-1:0] wy;
      logic signed [PROD_W-1:0] zx;
   } prod_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic signed [SUM_W-1:0] sp;
      logic                    clamp;
   } terms_type;

   typedef struct packed {
      terms_type          t;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
   } sqrt_type;

   typedef struct packed {
      logic signed [CX_W-1:0]  x;
      logic signed [CX_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic                    fixed;
   } lane_type;

   typedef struct packed {
      lane_type roll;
      lane_type pitch;
      lane_type yaw;
      logic     clamp;
      logic     neg;
   } cordic_type;

   // arctangent of 2^-i in q.20 radians
   function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:  v = ANG_W'(823550);
         1:  v = ANG_W'(486170);
         2:  v = ANG_W'(256879);
         3:  v = ANG_W'(130396);
         4:  v = ANG_W'(65451);
         5:  v = ANG_W'(32757);
         6:  v = ANG_W'(16383);
         7:  v = ANG_W'(8192);
         8:  v = ANG_W'(4096);
         9:  v = ANG_W'(2048);
         10: v = ANG_W'(1024);
         11: v = ANG_W'(512);
         12: v = ANG_W'(256);
         13: v = ANG_W'(128);
         14: v = ANG_W'(64);
         15: v = ANG_W'(32);
         16: v = ANG_W'(16);
         17: v = ANG_W'(8);
         18: v = ANG_W'(4);
         19: v = ANG_W'(2);
         20: v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // quadrant fold and axis cases ahead of the vectoring iterations
   function automatic lane_type lane_init(input logic signed [CX_W-1:0] y,
                                          input logic signed [CX_W-1:0] x);
      lane_type l;
      l.x     = x;
      l.y     = y;
      l.z     = '0;
      l.fixed = 1'b0;
      if (y == 0) begin
         l.fixed = 1'b1;
         l.z     = (x < 0) ? PI_Q20 : '0;
      end else if (x == 0) begin
         l.fixed = 1'b1;
         l.z     = (y > 0) ? HALF_PI_Q20 : -HALF_PI_Q20;
      end else if (x < 0) begin
         if (y > 0) begin
            l.x = y;
            l.y = -x;
            l.z = HALF_PI_Q20;
         end else begin
            l.x = -y;
            l.y = x;
            l.z = -HALF_PI_Q20;
         end
      end
      return l;
   endfunction

endpackage

>>> rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// unit quaternion in q1.14 to roll and yaw in q2.13 and pitch in q1.13 radians
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion transaction is taken every clock while
// req_stall is low. The stages are the products and sums (3 stages), the
// bit-per-stage square root for the pitch cosine (29 stages), the CORDIC
// entry stage, one stage per CORDIC iteration, min(CORDIC_STAGES, 24) in all,
// and the output register. The whole pipeline advances together; req_stall
// rises only while a finished result sits in the output register and rsp_stall
// is high. Pitch is clamped to +-pi/2 with gimbal_clamped set when the pitch
// term reaches magnitude one.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles
   import q2e_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_gimbal_clamped
);

   // number of cordic iterations actually used
   localparam int NIT = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   // global pipeline advance
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage 1: nine products ----------------
   prod_type p_in, p_ff;
   logic     v_p_ff;

   always_comb begin
      p_in.wx = PROD_W'(req_quat_w * req_quat_x);
      p_in.yz = PROD_W'(req_quat_y * req_quat_z);
      p_in.xx = PROD_W'(req_quat_x * req_quat_x);
      p_in.yy = PROD_W'(req_quat_y * req_quat_y);
      p_in.wz = PROD_W'(req_quat_w * req_quat_z);
      p_in.xy = PROD_W'(req_quat_x * req_quat_y);
      p_in.zz = PROD_W'(req_quat_z * req_quat_z);
      p_in.wy = PROD_W'(req_quat_w * req_quat_y);
      p_in.zx = PROD_W'(req_quat_z * req_quat_x);
   end

   // ---------------- stage 2: sums of products in q.28 ----------------
   terms_type t_in, t_ff;
   logic      v_t_ff;

   always_comb begin
      t_in.sr = (SUM_W'(p_ff.wx) + SUM_W'(p_ff.yz)) <<< 1;
      t_in.cr = ONE_Q28 - ((SUM_W'(p_ff.xx) + SUM_W'(p_ff.yy)) <<< 1);
      t_in.sy = (SUM_W'(p_ff.wz) + SUM_W'(p_ff.xy)) <<< 1;
      t_in.cy = ONE_Q28 - ((SUM_W'(p_ff.yy) + SUM_W'(p_ff.zz)) <<< 1);
      t_in.sp = (SUM_W'(p_ff.wy) - SUM_W'(p_ff.zx)) <<< 1;
      // pitch term at or beyond one in magnitude
      t_in.clamp = (t_in.sp >= ONE_Q28) || (t_in.sp <= -ONE_Q28);
   end

   // ---------------- stage 3: 1 - sp^2 in q.56 ----------------
   logic signed [SUM_W-1:0] sp_abs;
   logic [27:0]             sp_mag;
   logic [55:0]             sp_sq;
   sqrt_type                sq_ff [0:ROOT_W];
   sqrt_type                sq_in [0:ROOT_W];
   logic                    v_sq_ff [0:ROOT_W];

   always_comb begin
      sp_abs       = (t_ff.sp < 0) ? -t_ff.sp : t_ff.sp;
      sp_mag       = sp_abs[27:0];
      sp_sq        = sp_mag * sp_mag;
      sq_in[0].t    = t_ff;
      sq_in[0].rem  = (REM_W'(1) << 56) - REM_W'(sp_sq);
      sq_in[0].root = '0;
   end

   // ---------------- square root, one result bit per stage ----------------
   genvar j;
   generate
      for (j = 0; j < ROOT_W; j++) begin : g_sqrt
         localparam int K = ROOT_W - 1 - j;
         logic [REM_W-1:0] trial;
         always_comb begin
            trial = (REM_W'(sq_ff[j].root) << (K + 1)) + (REM_W'(1) << (2 * K));
            sq_in[j+1] = sq_ff[j];
            if (sq_ff[j].rem >= trial) begin
               sq_in[j+1].rem     = sq_ff[j].rem - trial;
               sq_in[j+1].root[K] = 1'b1;
            end
         end
      end
   endgenerate

   // ---------------- cordic entry and iterations ----------------
   cordic_type cd_ff [0:NIT];
   cordic_type cd_in [0:NIT];
   logic       v_cd_ff [0:NIT];

   always_comb begin
      cd_in[0].roll  = lane_init(CX_W'(sq_ff[ROOT_W].t.sr), CX_W'(sq_ff[ROOT_W].t.cr));
      cd_in[0].yaw   = lane_init(CX_W'(sq_ff[ROOT_W].t.sy), CX_W'(sq_ff[ROOT_W].t.cy));
      cd_in[0].pitch = lane_init(CX_W'(sq_ff[ROOT_W].t.sp),
                                 signed'(CX_W'(sq_ff[ROOT_W].root)));
      cd_in[0].clamp = sq_ff[ROOT_W].t.clamp;
      cd_in[0].neg   = sq_ff[ROOT_W].t.sp < 0;
   end

   generate
      for (j = 0; j < NIT; j++) begin : g_cordic
         function automatic lane_type rotate(input lane_type l);
            lane_type r;
            r = l;
            if (!l.fixed) begin
               if (l.y > 0) begin
                  r.x = l.x + (l.y >>> j);
                  r.y = l.y - (l.x >>> j);
                  r.z = l.z + atan_q20(j);
               end else begin
                  r.x = l.x - (l.y >>> j);
                  r.y = l.y + (l.x >>> j);
                  r.z = l.z - atan_q20(j);
               end
            end
            return r;
         endfunction

         always_comb begin
            cd_in[j+1]       = cd_ff[j];
            cd_in[j+1].roll  = rotate(cd_ff[j].roll);
            cd_in[j+1].pitch = rotate(cd_ff[j].pitch);
            cd_in[j+1].yaw   = rotate(cd_ff[j].yaw);
         end
      end
   endgenerate

   // ---------------- output rounding to q2.13 (pitch q1.13) ----------------
   logic signed [ANG_W-1:0] roll_rnd, pitch_rnd, yaw_rnd;
   logic signed [15:0]      roll_in, yaw_in;
   logic signed [14:0]      pitch_in;
   logic signed [15:0]      roll_ff, yaw_ff;
   logic signed [14:0]      pitch_ff;
   logic                    clamp_ff;

   always_comb begin
      roll_rnd  = (cd_ff[NIT].roll.z + ROUND_Q20) >>> 7;
      pitch_rnd = (cd_ff[NIT].pitch.z + ROUND_Q20) >>> 7;
      yaw_rnd   = (cd_ff[NIT].yaw.z + ROUND_Q20) >>> 7;
      roll_in   = roll_rnd[15:0];
      yaw_in    = yaw_rnd[15:0];
      if (cd_ff[NIT].clamp) begin
         // gimbal lock: pitch pinned at +-pi/2 by the term's sign
         pitch_in = cd_ff[NIT].neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      end else begin
         pitch_in = pitch_rnd[14:0];
      end
   end

   // ---------------- registers ----------------
   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff     <= p_in;
         t_ff     <= t_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         clamp_ff <= cd_ff[NIT].clamp;
         for (int k = 0; k <= ROOT_W; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int k = 0; k <= NIT; k++) begin
            cd_ff[k] <= cd_in[k];
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff       <= 1'b0;
         v_t_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++) begin
            v_sq_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= NIT; k++) begin
            v_cd_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v_p_ff       <= req_valid;
         v_t_ff       <= v_p_ff;
         v_sq_ff[0]   <= v_t_ff;
         for (int k = 1; k <= ROOT_W; k++) begin
            v_sq_ff[k] <= v_sq_ff[k-1];
         end
         v_cd_ff[0]   <= v_sq_ff[ROOT_W];
         for (int k = 1; k <= NIT; k++) begin
            v_cd_ff[k] <= v_cd_ff[k-1];
         end
         rsp_valid_ff <= v_cd_ff[NIT];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_roll_angle     = roll_ff;
   assign rsp_pitch_angle    = pitch_ff;
   assign rsp_yaw_angle      = yaw_ff;
   assign rsp_gimbal_clamped = clamp_ff;

endmodule
